@@ rtl/rqpc_pkg.sv @@
// Shared item types and operation codes for the ring queue with peek cursor.
package rqpc_pkg;

  localparam int DataW  = 32;
  localparam int CountW = 8;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_PEEK   = 3'd2;
  localparam logic [2:0] KIND_RWND   = 3'd3;
  localparam logic [2:0] KIND_DELETE = 3'd4;
  localparam logic [2:0] KIND_CLEAR  = 3'd5;

  localparam logic [CountW-1:0] CAP_RESET = 8'd255;

  typedef struct packed {
    logic [2:0]        kind;
    logic [DataW-1:0]  item_data;
    logic [CountW-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [DataW-1:0]  out_data;
    logic [CountW-1:0] occupancy;
  } out_item_t;

  // Result stage handed from the pointer logic to the output side.
  typedef struct packed {
    logic              valid;
    logic              status;
    logic              rd_sel;
    logic [CountW-1:0] occupancy;
  } stat_t;

endpackage

@@ rtl/rqpc_mem.sv @@
// Slot store: one write port, one registered read port.
module rqpc_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rqpc_ctrl.sv @@
// Head, tail, cursor and count registers; decodes one operation per cycle.
module rqpc_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  rqpc_pkg::in_item_t          in_item,
  input  logic                        cfg_we,
  input  logic [rqpc_pkg::CountW-1:0] cfg_wdata,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  output rqpc_pkg::stat_t             stat
);

  localparam logic [rqpc_pkg::CountW-1:0] LastMax = rqpc_pkg::CountW'(DEPTH - 1);

  logic [rqpc_pkg::CountW-1:0] cap_r;
  logic [AW-1:0]               head_r, head_nxt;
  logic [AW-1:0]               tail_r, tail_nxt;
  logic [AW-1:0]               cur_r, cur_nxt;
  logic [rqpc_pkg::CountW-1:0] total_r, total_nxt;
  rqpc_pkg::stat_t             stat_r, stat_nxt;

  logic [rqpc_pkg::CountW-1:0] last;
  logic [AW-1:0]               tail_inc, head_inc, cur_inc;
  logic [rqpc_pkg::CountW:0]   slots, del_sum, del_wrap;
  logic [AW-1:0]               del_head;

  // Last usable slot index; the ring holds last+1 slots.
  always_comb begin
    if (cap_r == '0) begin
      last = rqpc_pkg::CountW'(1);
    end else if (cap_r > LastMax) begin
      last = LastMax;
    end else begin
      last = cap_r;
    end
  end

  assign tail_inc = (rqpc_pkg::CountW'(tail_r) == last) ? '0 : tail_r + AW'(1);
  assign head_inc = (rqpc_pkg::CountW'(head_r) == last) ? '0 : head_r + AW'(1);
  assign cur_inc  = (rqpc_pkg::CountW'(cur_r)  == last) ? '0 : cur_r  + AW'(1);

  assign slots    = {1'b0, last} + 9'(1);
  assign del_sum  = 9'(head_r) + {1'b0, in_item.count};
  assign del_wrap = (del_sum >= slots) ? del_sum - slots : del_sum;
  assign del_head = (del_wrap >= slots) ? '0 : AW'(del_wrap);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    total_nxt = total_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = tail_inc;
    mem_raddr = (in_item.kind == rqpc_pkg::KIND_REMOVE) ? head_inc : cur_inc;
    stat_nxt  = '0;
    if (accept) begin
      stat_nxt.valid = 1'b1;
      unique case (in_item.kind)
        rqpc_pkg::KIND_ADD: begin
          if (tail_inc == head_r) begin
            stat_nxt.status = 1'b1;
          end else begin
            mem_we    = 1'b1;
            tail_nxt  = tail_inc;
            total_nxt = total_r + 8'd1;
          end
        end
        rqpc_pkg::KIND_REMOVE: begin
          if (head_r == tail_r) begin
            stat_nxt.status = 1'b1;
          end else begin
            mem_re          = 1'b1;
            stat_nxt.rd_sel = 1'b1;
            head_nxt        = head_inc;
            cur_nxt         = head_inc;
            if (total_r != '0) begin
              total_nxt = total_r - 8'd1;
            end
          end
        end
        rqpc_pkg::KIND_PEEK: begin
          if (cur_r == tail_r) begin
            stat_nxt.status = 1'b1;
          end else begin
            mem_re          = 1'b1;
            stat_nxt.rd_sel = 1'b1;
            cur_nxt         = cur_inc;
          end
        end
        rqpc_pkg::KIND_RWND: begin
          cur_nxt = head_r;
        end
        rqpc_pkg::KIND_DELETE: begin
          if (in_item.count > total_r) begin
            stat_nxt.status = 1'b1;
            head_nxt        = tail_r;
            cur_nxt         = tail_r;
            total_nxt       = '0;
          end else begin
            head_nxt  = del_head;
            cur_nxt   = del_head;
            total_nxt = total_r - in_item.count;
          end
        end
        rqpc_pkg::KIND_CLEAR: begin
          head_nxt  = tail_r;
          cur_nxt   = tail_r;
          total_nxt = '0;
        end
        default: begin
          stat_nxt.status = 1'b1;
        end
      endcase
    end
    stat_nxt.occupancy = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= rqpc_pkg::CAP_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      cur_r   <= '0;
      total_r <= '0;
      stat_r  <= '0;
    end else begin
      stat_r <= stat_nxt;
      // A capacity write drops everything held.
      if (cfg_we) begin
        cap_r   <= cfg_wdata;
        head_r  <= '0;
        tail_r  <= '0;
        cur_r   <= '0;
        total_r <= '0;
      end else begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        cur_r   <= cur_nxt;
        total_r <= total_nxt;
      end
    end
  end

  assign stat = stat_r;

endmodule

@@ rtl/ring_queue_with_peek_cursor_core.sv @@
// Top level of the ring queue with peek cursor.
//
// Input channel: an item (kind, item_data, count) is taken at a clock edge
// where start is high and busy is low. busy stays low, so an item may be
// issued on every cycle.
// Result channel: one result per item, shown for exactly one cycle with
// out_valid high, in the cycle after the item is taken (throughput
// one item per cycle). Results leave in issue order; the receiver cannot
// stall them and must take each on the cycle it appears.
// Each item does at most one slot access and its pointer updates in the
// cycle it is taken; the slot store's registered read port supplies
// out_data on the following cycle.
// Configuration: cfg_we with cfg_wdata writes the capacity and empties the
// queue. Write only when no result is outstanding.
// Reset (rst_n low, synchronous): the queue is empty, capacity is 255 and
// no result is pending. Slot contents are not cleared; empty slots are
// never read.
module ring_queue_with_peek_cursor_core #(
  parameter int SLOT_DEPTH = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  rqpc_pkg::in_item_t          in_item,
  output logic                        out_valid,
  output rqpc_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [rqpc_pkg::CountW-1:0] cfg_wdata
);

  // An 8-bit capacity never reaches past slot 255.
  localparam int DepthUsed = (SLOT_DEPTH < 256) ? SLOT_DEPTH : 256;
  localparam int Aw        = $clog2(DepthUsed);
  localparam int StoreW    = (DATA_WIDTH < rqpc_pkg::DataW) ? DATA_WIDTH : rqpc_pkg::DataW;

  logic            accept;
  logic            mem_we, mem_re;
  logic [Aw-1:0]   mem_waddr, mem_raddr;
  logic [StoreW-1:0] mem_rdata;
  rqpc_pkg::stat_t stat;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  rqpc_ctrl #(
    .DEPTH (DepthUsed),
    .AW    (Aw)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .stat      (stat)
  );

  rqpc_mem #(
    .DEPTH (DepthUsed),
    .WIDTH (StoreW),
    .AW    (Aw)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (StoreW'(in_item.item_data)),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid          = stat.valid;
  assign out_item.status    = stat.status;
  assign out_item.occupancy = stat.occupancy;
  assign out_item.out_data  = stat.rd_sel ? rqpc_pkg::DataW'(mem_rdata) : '0;

endmodule

@@ rtl/rqpc_chk.sv @@
// Port-level checker for the ring queue core, with its bind.
module rqpc_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input rqpc_pkg::in_item_t          in_item,
  input logic                        out_valid,
  input rqpc_pkg::out_item_t         out_item,
  input logic                        cfg_we
);

  logic accept;
  assign accept = start && !busy;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("no result one cycle after an accepted item");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without an accepted item");

  a_data_on_success: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_data != '0) |-> (out_item.status == 1'b0))
    else $error("data returned with a failing status");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_we && in_item.kind == rqpc_pkg::KIND_CLEAR)
      |=> (out_item.status == 1'b0 && out_item.occupancy == '0))
    else $error("clear did not empty the queue");

  a_bad_kind_fails: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.kind > rqpc_pkg::KIND_CLEAR))
      |=> (out_item.status == 1'b1 && out_item.out_data == '0))
    else $error("unused kind did not fail");

endmodule

bind ring_queue_with_peek_cursor_core rqpc_chk u_rqpc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item),
  .cfg_we    (cfg_we)
);
